@@ rtl/hek_pkg.sv @@
// shared types, constants and fixed-point helpers for the henon escape-time kernel
// no dependencies
package hek_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int ITER_BITS   = 12;
    localparam int DW          = 48;
    localparam int CW          = 15;
    localparam int NREGS       = 8;
    localparam int RIDX_W      = 3;

    localparam logic signed [DW:0] ESC_LIMIT = 49'sd42949672960000;
    localparam logic [CW-1:0]      COLOR_OFS = 15'd21;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_FWD  = 2'd1,
        OP_BWD  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_C_RE    = 3'd0,
        REG_C_IM    = 3'd1,
        REG_B_RE    = 3'd2,
        REG_B_IM    = 3'd3,
        REG_BINV_RE = 3'd4,
        REG_BINV_IM = 3'd5,
        REG_EINV_RE = 3'd6,
        REG_EINV_IM = 3'd7
    } reg_idx_t;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,   // start one product
        ST_WAIT,    // product in flight
        ST_RD,      // table read in flight
        ST_ADD,     // horner add of the table entry
        ST_CHECK,   // limit and escape test
        ST_DONE
    } state_t;

    // product groups of a point
    typedef enum logic [1:0] {
        PH_Y,       // y = v * eig_inv
        PH_HORN,    // acc = (acc + a[k]) * t
        PH_STEP,    // map step products
        PH_MAG      // magnitudes
    } phase_t;

    typedef logic signed [DW-1:0] fix_t;

    // saturate a 49-bit sum to 48 bits
    function automatic fix_t sat49(input logic signed [DW:0] v);
        fix_t r;
        r = v[DW-1:0];
        if (v[DW] != v[DW-1])
            r = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        return r;
    endfunction

endpackage

@@ rtl/henon_escape_time_kernel_core.sv @@
// top level of the henon escape-time kernel: sequencer, registers, port logic
// uses hek_pkg, hek_mul, hek_table
//
// usage
//   input channel in_valid/in_stall carries op, coef_index, value_re, value_im,
//   max_iter. a load word (op 0) writes one table entry and gives no result;
//   a point word (op 1 forward, op 2 backward) gives one color_index word on
//   out_valid/out_stall. op 3 is dropped.
//   config channel cfg_valid/cfg_ready with cfg_index/cfg_data writes the
//   eight map registers; it is always ready.
// arithmetic and throughput
//   all products run through one 48x48 multiplier, four 24x24 partial
//   products each; the next product is issued once the last one is done.
//   a point needs one complex multiply for y, two horner passes of
//   TABLE_DEPTH-1 complex multiplies each, a table read and add per term,
//   then per map step 8 step products, 4 magnitudes and one test.
//   load and op 3 words can follow back to back while no point is in
//   flight and no result waits.
// reset
//   registers read zero and every table entry reads zero until loaded.
// stall
//   the result sits in an output register until taken; no new word is
//   accepted while it waits, the next is taken from the cycle after.
module henon_escape_time_kernel_core
    import hek_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [5:0]           coef_index,
    input  logic signed [DW-1:0] value_re,
    input  logic signed [DW-1:0] value_im,
    input  logic [11:0]          max_iter,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [CW-1:0] color_index,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RIDX_W-1:0]    cfg_index,
    input  logic [DW-1:0]        cfg_data
);

    state_t state_reg, state_next;
    phase_t ph_reg, ph_next;
    fix_t   cfg_reg [NREGS];
    fix_t   acc_re_reg, acc_im_reg, t_re_reg, t_im_reg;
    fix_t   vre_reg, vim_reg;
    fix_t   pr_reg [8];
    logic [2:0] pi_reg, pi_next;
    logic [2:0] last_pi;
    logic       sec_reg, sec_next;     // 0 horner on x, 1 on y
    logic       bwd_reg;
    logic [TAB_AW-1:0] k_reg, k_next;
    logic [ITER_BITS-1:0] it_reg, it_next, mi_reg;
    fix_t   xi_reg, yi_reg, xr_reg, yr_reg;
    fix_t   ax_reg, ay_reg;
    logic signed [CW-1:0] col_reg, col_next;
    logic   ov_reg;

    logic   acc_in;
    logic   mstart, mdone;
    fix_t   ma, mb, mp;
    fix_t   tre, tim;
    logic   tbl_we;

    // horner sum of accumulator and table entry
    fix_t   sre, sim;
    logic signed [DW:0] dif;
    fix_t   w0, w1, w2;

    assign acc_in    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE) || ov_reg;
    assign cfg_ready = 1'b1;
    assign tbl_we    = acc_in && (op == OP_LOAD);

    hek_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart),
        .a     (ma),
        .b     (mb),
        .done  (mdone),
        .p     (mp)
    );

    hek_table u_tab (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tbl_we),
        .waddr (coef_index[TAB_AW-1:0]),
        .wre   (value_re),
        .wim   (value_im),
        .raddr (k_reg),
        .rre   (tre),
        .rim   (tim)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_valid && cfg_ready)
            cfg_reg[cfg_index] <= cfg_data;
    end

    assign sre = sat49(49'(acc_re_reg) + 49'(tre));
    assign sim = sat49(49'(acc_im_reg) + 49'(tim));

    // products of a complex multiply come as re*re, im*im, re*im, im*re
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (ph_reg)
            PH_Y:
            begin
                ma = pi_reg[0] ? vim_reg : vre_reg;
                mb = (pi_reg[0] ^ pi_reg[1]) ? cfg_reg[REG_EINV_IM] : cfg_reg[REG_EINV_RE];
            end
            PH_HORN:
            begin
                ma = pi_reg[0] ? acc_im_reg : acc_re_reg;
                mb = (pi_reg[0] ^ pi_reg[1]) ? t_im_reg : t_re_reg;
            end
            PH_STEP:
            begin
                if (!bwd_reg)
                begin
                    // b*y then x*x
                    case (pi_reg)
                        3'd0: begin ma = cfg_reg[REG_B_RE]; mb = yr_reg; end
                        3'd1: begin ma = cfg_reg[REG_B_IM]; mb = yi_reg; end
                        3'd2: begin ma = cfg_reg[REG_B_RE]; mb = yi_reg; end
                        3'd3: begin ma = cfg_reg[REG_B_IM]; mb = yr_reg; end
                        3'd4: begin ma = xr_reg; mb = xr_reg; end
                        3'd5: begin ma = xi_reg; mb = xi_reg; end
                        3'd6: begin ma = xr_reg; mb = xi_reg; end
                        default: begin ma = xi_reg; mb = xr_reg; end
                    endcase
                end
                else
                begin
                    // y*y then (x - y^2 - c) * binv
                    case (pi_reg)
                        3'd0: begin ma = yr_reg; mb = yr_reg; end
                        3'd1: begin ma = yi_reg; mb = yi_reg; end
                        3'd2: begin ma = yr_reg; mb = yi_reg; end
                        3'd3: begin ma = yi_reg; mb = yr_reg; end
                        3'd4: begin ma = acc_re_reg; mb = cfg_reg[REG_BINV_RE]; end
                        3'd5: begin ma = acc_im_reg; mb = cfg_reg[REG_BINV_IM]; end
                        3'd6: begin ma = acc_re_reg; mb = cfg_reg[REG_BINV_IM]; end
                        default: begin ma = acc_im_reg; mb = cfg_reg[REG_BINV_RE]; end
                    endcase
                end
            end
            PH_MAG:
            begin
                case (pi_reg[1:0])
                    2'd0: begin ma = xr_reg; mb = xr_reg; end
                    2'd1: begin ma = xi_reg; mb = xi_reg; end
                    2'd2: begin ma = yr_reg; mb = yr_reg; end
                    default: begin ma = yi_reg; mb = yi_reg; end
                endcase
            end
            default: ;
        endcase
    end

    assign w0 = sat49(49'(pr_reg[0]) - 49'(pr_reg[1]));
    assign w1 = sat49(49'(pr_reg[2]) + 49'(pr_reg[3]));
    assign w2 = sat49(49'(pr_reg[4]) - 49'(pr_reg[5]));
    assign dif = bwd_reg ? 49'(ay_reg) - 49'(ax_reg) : 49'(ax_reg) - 49'(ay_reg);
    assign last_pi = (ph_reg == PH_STEP) ? 3'd7 : 3'd3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= PH_Y;
            pi_reg    <= '0;
            sec_reg   <= 1'b0;
            k_reg     <= '0;
            it_reg    <= '0;
            col_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            pi_reg    <= pi_next;
            sec_reg   <= sec_next;
            k_reg     <= k_next;
            it_reg    <= it_next;
            col_reg   <= col_next;
            if (state_reg == ST_DONE)
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        pi_next    = pi_reg;
        sec_next   = sec_reg;
        k_next     = k_reg;
        it_next    = it_reg;
        col_next   = col_reg;
        mstart     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc_in && (op == OP_FWD || op == OP_BWD))
                begin
                    state_next = ST_ISSUE;
                    ph_next    = PH_Y;
                    pi_next    = '0;
                end
            end
            ST_ISSUE:
            begin
                mstart     = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (mdone)
                begin
                    if (pi_reg != last_pi)
                    begin
                        pi_next    = pi_reg + 3'd1;
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        pi_next = '0;
                        case (ph_reg)
                            PH_Y:
                            begin
                                sec_next   = 1'b0;
                                k_next     = TAB_AW'(TABLE_DEPTH - 1);
                                state_next = ST_RD;
                            end
                            PH_HORN:
                            begin
                                k_next     = k_reg - TAB_AW'(1);
                                state_next = ST_RD;
                            end
                            PH_STEP:
                            begin
                                ph_next    = PH_MAG;
                                state_next = ST_ISSUE;
                            end
                            default:
                            begin
                                // magnitudes done, one more step counted
                                it_next    = it_reg + ITER_BITS'(1);
                                state_next = ST_CHECK;
                            end
                        endcase
                    end
                end
            end
            ST_RD:
                state_next = ST_ADD;
            ST_ADD:
            begin
                if (k_reg != '0)
                begin
                    ph_next    = PH_HORN;
                    state_next = ST_ISSUE;
                end
                else if (!sec_reg)
                begin
                    // second pass on y
                    sec_next   = 1'b1;
                    k_next     = TAB_AW'(TABLE_DEPTH - 1);
                    state_next = ST_RD;
                end
                else
                begin
                    it_next    = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // limit first: a point that reaches max_iter does not escape
                if (it_reg == mi_reg)
                begin
                    col_next   = '1;
                    state_next = ST_DONE;
                end
                else if (dif >= ESC_LIMIT)
                begin
                    col_next   = (xi_reg[DW-1] || xi_reg == '0)
                                 ? CW'({it_reg, 1'b0}) + COLOR_OFS : CW'({it_reg, 1'b0});
                    state_next = ST_DONE;
                end
                else
                begin
                    ph_next    = PH_STEP;
                    pi_next    = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            vre_reg <= value_re;
            vim_reg <= value_im;
            bwd_reg <= (op == OP_BWD);
            mi_reg  <= max_iter[ITER_BITS-1:0];
        end
        if (state_reg == ST_WAIT && mdone)
        begin
            pr_reg[pi_reg] <= mp;
            if (pi_reg == last_pi)
            begin
                case (ph_reg)
                    PH_Y:
                    begin
                        // horner on x first: t = v
                        t_re_reg   <= vre_reg;
                        t_im_reg   <= vim_reg;
                        acc_re_reg <= '0;
                        acc_im_reg <= '0;
                        yr_reg     <= w0;
                        yi_reg     <= sat49(49'(pr_reg[2]) + 49'(mp));
                    end
                    PH_HORN:
                    begin
                        acc_re_reg <= w0;
                        acc_im_reg <= sat49(49'(pr_reg[2]) + 49'(mp));
                    end
                    PH_STEP:
                    begin
                        if (!bwd_reg)
                        begin
                            // t = b*y + x*x + c ; y = x ; x = t
                            yr_reg <= xr_reg;
                            yi_reg <= xi_reg;
                            xr_reg <= sat49(49'(sat49(49'(w0) + 49'(w2))) + 49'(cfg_reg[REG_C_RE]));
                            xi_reg <= sat49(49'(sat49(49'(w1)
                                      + 49'(sat49(49'(pr_reg[6]) + 49'(mp)))))
                                      + 49'(cfg_reg[REG_C_IM]));
                        end
                        else
                        begin
                            xr_reg <= yr_reg;
                            xi_reg <= yi_reg;
                            yr_reg <= w2;
                            yi_reg <= sat49(49'(pr_reg[6]) + 49'(mp));
                        end
                    end
                    default:
                    begin
                        ax_reg <= sat49(49'(pr_reg[0]) + 49'(pr_reg[1]));
                        ay_reg <= sat49(49'(pr_reg[2]) + 49'(mp));
                    end
                endcase
            end
            // backward: after y^2 products form (x - y^2 - c) in acc
            if (ph_reg == PH_STEP && bwd_reg && pi_reg == 3'd3)
            begin
                acc_re_reg <= sat49(49'(sat49(49'(xr_reg) - 49'(w0))) - 49'(cfg_reg[REG_C_RE]));
                acc_im_reg <= sat49(49'(sat49(49'(xi_reg)
                              - 49'(sat49(49'(pr_reg[2]) + 49'(mp)))))
                              - 49'(cfg_reg[REG_C_IM]));
            end
        end
        if (state_reg == ST_ADD)
        begin
            if (k_reg != '0)
            begin
                acc_re_reg <= sre;
                acc_im_reg <= sim;
            end
            else if (!sec_reg)
            begin
                // x done, second pass runs with t = y
                xr_reg     <= sre;
                xi_reg     <= sim;
                t_re_reg   <= yr_reg;
                t_im_reg   <= yi_reg;
                acc_re_reg <= '0;
                acc_im_reg <= '0;
            end
            else
            begin
                yr_reg <= sre;
                yi_reg <= sim;
                ax_reg <= '0;
                ay_reg <= '0;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign color_index = col_reg;

    // no word taken while a point is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input accepted while busy");
    // result held until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(color_index)))
        else $error("result changed under stall");
    // a result only follows a finished point
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result without finished point");

endmodule

@@ rtl/hek_mul.sv @@
// shared multi-cycle Q15.32 multiplier, magnitude rounding with saturation
// uses hek_pkg; 24x24 partial products, one per cycle
module hek_mul
    import hek_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  fix_t a,
    input  fix_t b,
    output logic done,
    output fix_t p
);

    logic [DW-1:0] ua_reg, ub_reg;
    logic          neg_reg;
    logic [2:0]    step_reg;
    logic          busy_reg;
    logic [95:0]   acc_reg;
    logic [47:0]   pp;
    logic [23:0]   opa, opb;
    logic [95:0]   pp_sh;
    logic [64:0]   r;
    logic [DW-1:0] ua_in, ub_in;

    assign ua_in = a[DW-1] ? DW'(-a) : DW'(a);
    assign ub_in = b[DW-1] ? DW'(-b) : DW'(b);

    always_comb
    begin
        opa   = step_reg[1] ? ua_reg[47:24] : ua_reg[23:0];
        opb   = step_reg[0] ? ub_reg[47:24] : ub_reg[23:0];
        pp    = opa * opb;
        pp_sh = 96'(pp) << (24 * (32'(step_reg[1]) + 32'(step_reg[0])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd3)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= ua_in;
            ub_reg  <= ub_in;
            neg_reg <= a[DW-1] ^ b[DW-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + pp_sh;
    end

    // round and saturate from the finished magnitude
    always_comb
    begin
        r = 65'(acc_reg[95:32]) + 65'(acc_reg[31]);
        if (neg_reg)
            p = (r > 65'h800000000000) ? {1'b1, 47'd0} : DW'(-r[DW-1:0]);
        else
            p = (r > 65'h7FFFFFFFFFFF) ? {1'b0, {47{1'b1}}} : r[DW-1:0];
    end

endmodule

@@ rtl/hek_table.sv @@
// coefficient table, one read port with registered data
// uses hek_pkg; valid bits give the cleared value after reset
module hek_table
    import hek_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [TAB_AW-1:0] waddr,
    input  fix_t              wre,
    input  fix_t              wim,
    input  logic [TAB_AW-1:0] raddr,
    output fix_t              rre,
    output fix_t              rim
);

    fix_t mem_re [TABLE_DEPTH];
    fix_t mem_im [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_reg;
    fix_t dre_reg, dim_reg;
    logic rv_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_re[waddr] <= wre;
            mem_im[waddr] <= wim;
        end
        dre_reg <= mem_re[raddr];
        dim_reg <= mem_im[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rv_reg  <= 1'b0;
        end
        else
        begin
            if (we)
                vld_reg[waddr] <= 1'b1;
            rv_reg <= vld_reg[raddr];
        end
    end

    assign rre = rv_reg ? dre_reg : '0;
    assign rim = rv_reg ? dim_reg : '0;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for henon_escape_time_kernel_core
// depends on rtl/hek_pkg.sv, rtl/henon_escape_time_kernel_core.sv, rtl/hek_mul.sv and rtl/hek_table.sv
`timescale 1ns / 100ps

module testbench;
    import hek_pkg::*;

    localparam int  WATCHDOG_LIMIT = 150000;  // cycles with no word moving on any channel
    localparam int  STEP_CAP       = 300;     // longest map run allowed per point
    localparam int  HOLD_CYCLES    = 6000;    // long receiver hold-off
    localparam int  DRAIN_CYCLES   = 40;      // a load can still be in flight after the last result
    localparam longint MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint MIN48 = -64'sh0000_8000_0000_0000;
    localparam longint ESCAPE_BOUND = 64'sd10000 <<< 32;

    typedef struct {
        longint re;
        longint im;
    } cnum_t;

    typedef struct {
        op_t        op;
        logic [5:0] idx;
        fix_t       re;
        fix_t       im;
        logic [11:0] iters;
    } work_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] op;
    logic [5:0] coef_index;
    logic signed [DW-1:0] value_re;
    logic signed [DW-1:0] value_im;
    logic [11:0] max_iter;
    logic out_valid;
    logic out_stall;
    logic signed [CW-1:0] color_index;
    logic cfg_valid;
    logic cfg_ready;
    logic [RIDX_W-1:0] cfg_index;
    logic [DW-1:0] cfg_data;

    henon_escape_time_kernel_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .coef_index  (coef_index),
        .value_re    (value_re),
        .value_im    (value_im),
        .max_iter    (max_iter),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color_index (color_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // shadow of the map registers and the coefficient table
    longint map_reg [NREGS];
    longint tab_re [TABLE_DEPTH];
    longint tab_im [TABLE_DEPTH];

    work_t pending_words [$];
    logic signed [CW-1:0] expected_colors [$];

    int errors;
    int n_loads;
    int n_points;
    int n_escapes;
    int n_colors_seen;
    int idle_cycles;
    bit in_quiet;       // sender never idles while set
    bit out_quiet;      // receiver never idles while set
    bit in_took;
    int hold_left;
    bit hold_done;

    // clock: 12 ns period
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ---------------- fixed-point predictor ----------------

    function automatic longint sat48(input longint v);
        if (v > MAX48)
            return MAX48;
        if (v < MIN48)
            return MIN48;
        return v;
    endfunction

    // product shifted right by 32, magnitude rounded half away from zero, saturated
    function automatic longint qmul(input longint a, input longint b);
        logic [95:0] prod;
        logic [63:0] mag;
        logic [95:0] ua;
        logic [95:0] ub;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        prod = ua * ub;
        mag = prod[95:32] + prod[31];
        if ((a < 0) != (b < 0))
        begin
            if (mag > 64'h0000_8000_0000_0000)
                mag = 64'h0000_8000_0000_0000;
            return -longint'(mag);
        end
        if (mag > 64'h0000_7FFF_FFFF_FFFF)
            return MAX48;
        return longint'(mag);
    endfunction

    function automatic cnum_t c_add(input cnum_t a, input cnum_t b);
        cnum_t r;
        r.re = sat48(a.re + b.re);
        r.im = sat48(a.im + b.im);
        return r;
    endfunction

    function automatic cnum_t c_sub(input cnum_t a, input cnum_t b);
        cnum_t r;
        r.re = sat48(a.re - b.re);
        r.im = sat48(a.im - b.im);
        return r;
    endfunction

    function automatic cnum_t c_mul(input cnum_t a, input cnum_t b);
        cnum_t r;
        r.re = sat48(qmul(a.re, b.re) - qmul(a.im, b.im));
        r.im = sat48(qmul(a.re, b.im) + qmul(a.im, b.re));
        return r;
    endfunction

    function automatic longint norm2(input cnum_t a);
        return sat48(qmul(a.re, a.re) + qmul(a.im, a.im));
    endfunction

    // manifold polynomial p + sum a[k] t^k, horner order from the top entry
    function automatic cnum_t manifold_at(input cnum_t t);
        cnum_t acc;
        cnum_t ak;
        acc = '{0, 0};
        for (int k = TABLE_DEPTH - 1; k > 0; k--)
        begin
            ak = '{tab_re[k], tab_im[k]};
            acc = c_mul(c_add(acc, ak), t);
        end
        ak = '{tab_re[0], tab_im[0]};
        return c_add(acc, ak);
    endfunction

    // escape color of one point; steps returns how many map steps the block runs
    function automatic logic signed [CW-1:0] escape_color(input op_t kind, input cnum_t z,
                                                          input int limit, output int steps);
        cnum_t x;
        cnum_t y;
        cnum_t t;
        cnum_t cc;
        cnum_t bb;
        cnum_t bi;
        cnum_t ei;
        longint ax;
        longint ay;
        int i;
        cc = '{map_reg[REG_C_RE], map_reg[REG_C_IM]};
        bb = '{map_reg[REG_B_RE], map_reg[REG_B_IM]};
        bi = '{map_reg[REG_BINV_RE], map_reg[REG_BINV_IM]};
        ei = '{map_reg[REG_EINV_RE], map_reg[REG_EINV_IM]};
        ax = 0;
        ay = 0;
        y = c_mul(z, ei);
        x = manifold_at(z);
        y = manifold_at(y);
        for (i = 0; i < limit; i++)
        begin
            if (kind == OP_FWD)
            begin
                if (ax - ay >= ESCAPE_BOUND)
                    break;
                t = c_add(c_add(c_mul(bb, y), c_mul(x, x)), cc);
                y = x;
                x = t;
            end
            else
            begin
                if (ay - ax >= ESCAPE_BOUND)
                    break;
                t = c_mul(c_sub(c_sub(x, c_mul(y, y)), cc), bi);
                x = y;
                y = t;
            end
            ax = norm2(x);
            ay = norm2(y);
        end
        steps = i;
        if (i < limit)
            return (x.im > 0) ? CW'(2 * i) : CW'(2 * i + 21);
        return -1;
    endfunction

    // ---------------- stimulus builders ----------------

    task automatic queue_load(input logic [5:0] idx, input longint re, input longint im);
        work_t w;
        w = '{OP_LOAD, idx, fix_t'(re), fix_t'(im), 12'($urandom)};
        tab_re[idx] = sat48(re);
        tab_im[idx] = sat48(im);
        pending_words.push_back(w);
        n_loads++;
    endtask

    // point word; a limit that would run the map too long is cut back to a small one
    task automatic queue_point(input op_t kind, input longint re, input longint im,
                               input int limit);
        work_t w;
        int steps;
        cnum_t z;
        logic signed [CW-1:0] color;
        z.re = re;
        z.im = im;
        color = escape_color(kind, z, limit, steps);
        if (steps > STEP_CAP)
        begin
            limit = $urandom_range(20);
            color = escape_color(kind, z, limit, steps);
        end
        w = '{kind, 6'($urandom), fix_t'(re), fix_t'(im), 12'(limit)};
        pending_words.push_back(w);
        expected_colors.push_back(color);
        n_points++;
        if (color != -1)
            n_escapes++;
    endtask

    task automatic queue_unused();
        work_t w;
        w = '{OP_NONE, 6'($urandom), fix_t'({$urandom, $urandom}),
              fix_t'({$urandom, $urandom}), 12'($urandom)};
        pending_words.push_back(w);
    endtask

    // ---------------- configuration channel ----------------

    task automatic write_reg(input reg_idx_t which, input longint val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= val[DW-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        map_reg[which] = longint'(fix_t'(val[DW-1:0]));
    endtask

    task automatic set_map(input longint c_re, input longint c_im, input longint b_re,
                           input longint b_im, input longint bi_re, input longint bi_im,
                           input longint ei_re, input longint ei_im);
        write_reg(REG_C_RE, c_re);
        write_reg(REG_C_IM, c_im);
        write_reg(REG_B_RE, b_re);
        write_reg(REG_B_IM, b_im);
        write_reg(REG_BINV_RE, bi_re);
        write_reg(REG_BINV_IM, bi_im);
        write_reg(REG_EINV_RE, ei_re);
        write_reg(REG_EINV_IM, ei_im);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // signed random value in +-2^bits
    function automatic longint rnd_bits(input int bits);
        longint v;
        v = longint'({$urandom, $urandom}) & ((64'sd1 <<< bits) - 1);
        return ($urandom_range(1)) ? -v : v;
    endfunction

    function automatic longint rnd_full();
        return longint'(fix_t'({$urandom, $urandom}));
    endfunction

    task automatic set_map_typical();
        set_map(rnd_bits(32), rnd_bits(32), rnd_bits(31), rnd_bits(30),
                rnd_bits(34), rnd_bits(34), rnd_bits(32), rnd_bits(32));
    endtask

    // wait until every queued word is in and every color is out, then let loads settle
    task automatic wait_idle();
        wait (pending_words.size() == 0 && !in_valid && expected_colors.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one phase of random traffic: mostly loads into the low entries and points
    task automatic random_phase(input int count);
        int pick;
        int lim;
        int k;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                k = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
                if ($urandom_range(9) == 0)
                    queue_load(6'(k), rnd_full(), rnd_full());
                else if (k <= 3)
                    queue_load(6'(k), rnd_bits(33), rnd_bits(33));
                else
                    queue_load(6'(k), rnd_bits(18), rnd_bits(18));
            end
            else if (pick < 95)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                    lim = $urandom_range(40);
                else if (pick < 95)
                    lim = $urandom_range(4095);
                else
                    lim = 4095;
                if ($urandom_range(7) == 0)
                    queue_point($urandom_range(1) ? OP_FWD : OP_BWD, rnd_full(), rnd_full(),
                                lim);
                else
                    queue_point($urandom_range(1) ? OP_FWD : OP_BWD, rnd_bits(36),
                                rnd_bits(36), lim);
            end
            else
                queue_unused();
        end
    endtask

    // ---------------- input driver ----------------

    always @(posedge clk)
        in_took <= in_valid && !in_stall;

    // presents the next word at the falling edge, holds it while stalled
    always @(negedge clk)
    begin
        work_t w;
        if (rst_n && !(in_valid && !in_took))
        begin
            if (pending_words.size() > 0 && (in_quiet || $urandom_range(99) >= 17))
            begin
                w = pending_words.pop_front();
                op         <= w.op;
                coef_index <= w.idx;
                value_re   <= w.re;
                value_im   <= w.im;
                max_iter   <= w.iters;
                in_valid   <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------- output monitor ----------------

    // receiver stall: random, one long hold-off after twenty results, quiet stretch
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && n_colors_seen == 20)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !out_quiet && ($urandom_range(99) < 17);
        end
    end

    always @(posedge clk)
    begin
        logic signed [CW-1:0] want;
        if (out_valid && !out_stall)
        begin
            n_colors_seen <= n_colors_seen + 1;
            if (expected_colors.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected color_index word, expected none, actual %0d",
                         $time, color_index);
            end
            else
            begin
                want = expected_colors.pop_front();
                if (color_index !== want)
                begin
                    errors++;
                    $display("%0t: color_index mismatch, expected %0d, actual %0d",
                             $time, want, color_index);
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d colors still pending", $time,
                     expected_colors.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------- test sequence ----------------

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_LOAD;
        coef_index = '0;
        value_re   = '0;
        value_im   = '0;
        max_iter   = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_C_RE;
        cfg_data   = '0;
        errors = 0;
        n_loads = 0;
        n_points = 0;
        n_escapes = 0;
        n_colors_seen = 0;
        idle_cycles = 0;
        in_quiet = 1'b0;
        out_quiet = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        for (int k = 0; k < NREGS; k++)
            map_reg[k] = 0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            tab_re[k] = 0;
            tab_im[k] = 0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: a point against the cleared table and reset registers first
        queue_point(OP_FWD, 64'sd1 <<< 32, 64'sd1 <<< 32, 3);
        wait_idle();
        // c = -0.5 + 0.25i, b = 0.3, 1/b ~ 3.333, 1/eig = 0.5
        set_map(-(64'sd1 <<< 31), 64'sd1 <<< 30, 64'sd1288490189, 0,
                64'sd14316557653, 0, 64'sd1 <<< 31, 0);
        queue_load(0, 64'sd429496730, -64'sd858993459);   // saddle point
        queue_load(1, 64'sd1 <<< 32, 0);                   // identity term
        queue_point(OP_FWD, 64'sd3 <<< 32, 64'sd2 <<< 32, 0);    // zero limit
        queue_point(OP_FWD, 64'sd3 <<< 32, 64'sd2 <<< 32, 1);    // first step always runs
        queue_point(OP_FWD, 64'sd200 <<< 32, 64'sd5 <<< 32, 4095);
        queue_point(OP_FWD, 64'sd200 <<< 32, -(64'sd5 <<< 32), 4095);
        queue_point(OP_BWD, 64'sd3 <<< 32, -(64'sd7 <<< 32), 50);
        queue_point(OP_BWD, -(64'sd150 <<< 32), 64'sd90 <<< 32, 2048);
        queue_point(OP_FWD, MAX48, MAX48, 20);             // field extremes
        queue_point(OP_BWD, MIN48, MIN48, 20);
        queue_point(OP_FWD, MAX48, MIN48, 7);
        queue_point(OP_FWD, 0, 0, 30);
        queue_unused();                                    // op 3 ignored
        queue_load(63, MAX48, MIN48);                      // top entry, saturating polynomial
        queue_point(OP_FWD, 64'sd1 <<< 32, 64'sd1 <<< 31, 10);
        queue_load(63, MIN48, MAX48);
        queue_point(OP_BWD, -(64'sd1 <<< 32), 64'sd1 <<< 31, 10);
        queue_load(63, 0, 0);
        queue_load(2, 64'sd1 <<< 31, -(64'sd1 <<< 30));
        queue_point(OP_FWD, 64'sd40 <<< 32, -(64'sd40 <<< 32), 100);
        queue_unused();
        queue_point(OP_BWD, 64'sd40 <<< 32, 64'sd40 <<< 32, 100);
        wait_idle();

        // random phases under different map settings, extremes among them
        set_map_typical();
        random_phase(130);
        wait_idle();

        set_map(MAX48, MAX48, MAX48, MAX48, MAX48, MAX48, MAX48, MAX48);
        random_phase(90);
        wait_idle();

        set_map(MIN48, MIN48, MIN48, MIN48, MIN48, MIN48, MIN48, MIN48);
        random_phase(90);
        wait_idle();

        set_map(rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                rnd_full(), rnd_full(), rnd_full(), rnd_full());
        random_phase(90);
        wait_idle();

        // stretch with no idling on either side
        set_map_typical();
        in_quiet = 1'b1;
        out_quiet = 1'b1;
        random_phase(110);
        wait_idle();
        in_quiet = 1'b0;
        out_quiet = 1'b0;

        set_map(0, 0, 0, 0, 0, 0, 0, 0);
        random_phase(40);
        wait_idle();

        set_map_typical();
        random_phase(175);
        wait_idle();

        $display("covered %0d table loads and %0d points (%0d escaped) over 8 map settings",
                 n_loads, n_points, n_escapes);
        $display("with random stalls on both sides and one long hold-off on the output");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
